### design/cftp_pkg.sv
// Package with the types and constants shared by the cEMI to TP frame builder files.
`timescale 1ns / 1ps
`default_nettype none
package cftp_pkg;

   // cEMI byte offsets (additional-info length taken as zero)
   localparam logic [8:0] POS_CTRL1 = 9'd2;
   localparam logic [8:0] POS_CTRL2 = 9'd3;
   localparam logic [8:0] POS_DA_HI = 9'd6;
   localparam logic [8:0] POS_DA_LO = 9'd7;
   localparam logic [8:0] POS_LEN   = 9'd8;
   localparam logic [8:0] POS_TPDU  = 9'd9;

   localparam logic [15:0] SRC_RESET  = 16'h11FA;
   localparam logic [7:0]  CHECK_INIT = 8'hFF;

   // Most output bytes that one input byte can cause.
   localparam int MAX_RESULTS = 3;

   // Output queue.
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

   typedef struct packed {
      logic [7:0] out_byte;
      logic       frame_end;
   } entry_type;

endpackage
`default_nettype wire

### design/cemi_to_tp_frame_builder_top.sv
// Top level of the cEMI to twisted-pair frame builder with XOR check byte.
`timescale 1ns / 1ps
`default_nettype none
// An input byte's results are written into the output queue at its transfer. Throughput:
// one input byte per cycle while the 8-entry output queue has room for three entries;
// results leave one per cycle while rsp_tready is high; the drain sets the long-term pace.
// Reset (synchronous, active high) empties the queue, clears the frame state, sets the
// running check to 0xFF and loads the source address register with 0x11FA.
module cemi_to_tp_frame_builder_top (
   input  wire logic        clock,
   input  wire logic        reset,
   // Configuration: source address register.
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data,
   // Input stream of cEMI bytes.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] in_byte
   input  wire logic        req_tuser,   // [0] frame_start
   // Output stream of TP frame bytes.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [7:0] out_byte
   output logic             rsp_tlast    // frame_end
);

   // Frame state.
   logic [15:0] source_address_ff;
   logic [8:0]  byte_position_ff, byte_position_in;
   logic        frame_active_ff, frame_active_in;
   logic [7:0]  saved_ctrl2_ff, saved_ctrl2_in;
   logic [7:0]  tpdu_length_ff, tpdu_length_in;
   logic [7:0]  running_check_ff, running_check_in;

   // Output queue. Entries are payload and carry no reset.
   cftp_pkg::entry_type                  mem_ff [cftp_pkg::FIFO_DEPTH];
   logic [cftp_pkg::FIFO_AW-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [cftp_pkg::FIFO_AW-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [cftp_pkg::FIFO_CW-1:0]         count_ff, count_in;

   // Results of the current input transfer.
   cftp_pkg::entry_type res [cftp_pkg::MAX_RESULTS];
   logic [1:0]          res_count;

   logic       req_fire;
   logic       rsp_fire;
   logic       active_eff;
   logic [8:0] pos_eff;
   logic [7:0] check_eff;
   logic [8:0] last_pos;
   logic [7:0] in_byte;

   assign in_byte  = req_tdata;
   // Accept only while three free entries remain, so any byte's results fit.
   assign req_tready = (count_ff <=
                        cftp_pkg::FIFO_CW'(cftp_pkg::FIFO_DEPTH - cftp_pkg::MAX_RESULTS));
   assign req_fire = req_tvalid & req_tready;
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_fire = rsp_tvalid & rsp_tready;
   assign rsp_tdata = mem_ff[rd_ptr_ff].out_byte;
   assign rsp_tlast = mem_ff[rd_ptr_ff].frame_end;

   // A start byte restarts the frame, abandoning any frame in progress.
   always_comb begin
      active_eff = req_tuser | frame_active_ff;
      pos_eff    = req_tuser ? 9'd0 : byte_position_ff;
      check_eff  = req_tuser ? cftp_pkg::CHECK_INIT : running_check_ff;
      last_pos   = cftp_pkg::POS_TPDU + {1'b0, tpdu_length_ff};

      res_count        = 2'd0;
      for (int k = 0; k < cftp_pkg::MAX_RESULTS; k++) begin
         res[k] = '{out_byte: 8'h00, frame_end: 1'b0};
      end
      frame_active_in  = active_eff;
      saved_ctrl2_in   = saved_ctrl2_ff;
      tpdu_length_in   = tpdu_length_ff;
      running_check_in = check_eff;

      if (active_eff) begin
         if (pos_eff == cftp_pkg::POS_CTRL1) begin
            // ctrl1 is followed at once by the configured source address.
            res[0]    = '{out_byte: in_byte, frame_end: 1'b0};
            res[1]    = '{out_byte: source_address_ff[15:8], frame_end: 1'b0};
            res[2]    = '{out_byte: source_address_ff[7:0], frame_end: 1'b0};
            res_count = 2'd3;
            running_check_in = check_eff ^ in_byte ^ source_address_ff[15:8]
                               ^ source_address_ff[7:0];
         end else if (pos_eff == cftp_pkg::POS_CTRL2) begin
            saved_ctrl2_in = in_byte;
         end else if (pos_eff == cftp_pkg::POS_DA_HI || pos_eff == cftp_pkg::POS_DA_LO) begin
            res[0]    = '{out_byte: in_byte, frame_end: 1'b0};
            res_count = 2'd1;
            running_check_in = check_eff ^ in_byte;
         end else if (pos_eff == cftp_pkg::POS_LEN) begin
            tpdu_length_in = in_byte;
            res[0]    = '{out_byte: saved_ctrl2_ff | in_byte, frame_end: 1'b0};
            res_count = 2'd1;
            running_check_in = check_eff ^ (saved_ctrl2_ff | in_byte);
         end else if (pos_eff >= cftp_pkg::POS_TPDU) begin
            res[0]    = '{out_byte: in_byte, frame_end: 1'b0};
            res_count = 2'd1;
            running_check_in = check_eff ^ in_byte;
            if (pos_eff >= last_pos) begin
               // The check byte covers every byte before it, this TPDU byte too.
               res[1]    = '{out_byte: check_eff ^ in_byte, frame_end: 1'b1};
               res_count = 2'd2;
               frame_active_in = 1'b0;
            end
         end
      end

      byte_position_in = frame_active_in ? (pos_eff + 9'd1) : pos_eff;

      wr_ptr_in = wr_ptr_ff + cftp_pkg::FIFO_AW'(res_count);
      rd_ptr_in = rd_ptr_ff + cftp_pkg::FIFO_AW'(rsp_fire);
      count_in  = count_ff + cftp_pkg::FIFO_CW'(res_count)
                  - cftp_pkg::FIFO_CW'(rsp_fire);
      if (!req_fire) begin
         wr_ptr_in = wr_ptr_ff;
         count_in  = count_ff - cftp_pkg::FIFO_CW'(rsp_fire);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         source_address_ff <= cftp_pkg::SRC_RESET;
         byte_position_ff  <= '0;
         frame_active_ff   <= 1'b0;
         saved_ctrl2_ff    <= '0;
         tpdu_length_ff    <= '0;
         running_check_ff  <= cftp_pkg::CHECK_INIT;
         wr_ptr_ff         <= '0;
         rd_ptr_ff         <= '0;
         count_ff          <= '0;
      end else begin
         if (csr_wr_en) begin
            source_address_ff <= csr_wr_data;
         end
         if (req_fire) begin
            byte_position_ff <= byte_position_in;
            frame_active_ff  <= frame_active_in;
            saved_ctrl2_ff   <= saved_ctrl2_in;
            tpdu_length_ff   <= tpdu_length_in;
            running_check_ff <= running_check_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage: up to three consecutive entries written per transfer.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         for (int k = 0; k < cftp_pkg::MAX_RESULTS; k++) begin
            if (k < int'(res_count)) begin
               mem_ff[wr_ptr_ff + cftp_pkg::FIFO_AW'(k)] <= res[k];
            end
         end
      end
   end

endmodule
`default_nettype wire

### design/cftp_checker.sv
// Port-level checker for the frame builder top level and its bind statement.
`timescale 1ns / 1ps
`default_nettype none
module cftp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [7:0]  rsp_tdata,
   input wire logic        rsp_tlast
);

   // A result that is not taken stays offered and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp payload changed while stalled");

   // Reset leaves an empty queue that can take input.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("queue not empty after reset");

   // With nothing queued and no input transfer, nothing appears.
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid && !(req_tvalid && req_tready) |=> !rsp_tvalid)
      else $error("result appeared without an input transfer");

   // A check byte is never directly followed by another check byte.
   a_tlast_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> !(rsp_tvalid && rsp_tlast))
      else $error("two check bytes in a row");

endmodule

bind cemi_to_tp_frame_builder_top cftp_checker u_cftp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire
